// File: rtl/scr_pkg.sv
// Shared types and constants for the squares counter-based random generator.
// No dependencies.
`default_nettype none

package scr_pkg;

   localparam int unsigned WordBits = 64;
   localparam int unsigned HalfBits = 32;

   // Side data that travels down the pipeline next to each request
   typedef struct packed {
      logic                last;
      logic [WordBits-1:0] y;
      logic [WordBits-1:0] z;
   } ctx_type;

   function automatic logic [WordBits-1:0] swap_halves(input logic [WordBits-1:0] v);
      swap_halves = {v[HalfBits-1:0], v[WordBits-1:HalfBits]};
   endfunction

endpackage

`default_nettype wire

// File: rtl/scr_keymul.sv
// Forms y = counter*key and z = y + key over three register stages.
// Depends on scr_pkg.
`default_nettype none

module scr_keymul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [scr_pkg::WordBits-1:0]  counter,
   input  wire logic [scr_pkg::WordBits-1:0]  key,
   input  wire logic                          last_in,
   output logic                               out_valid,
   output scr_pkg::ctx_type                   out_ctx
);

   localparam int unsigned W = scr_pkg::WordBits;
   localparam int unsigned H = scr_pkg::HalfBits;

   // stage 1: partial products
   logic         v1_ff;
   logic [W-1:0] ll_ff;
   logic [H-1:0] cr_a_ff, cr_b_ff;
   logic [W-1:0] key1_ff;
   logic         last1_ff;

   // stage 2: product sum
   logic         v2_ff;
   logic [W-1:0] y2_ff;
   logic [W-1:0] key2_ff;
   logic         last2_ff;

   // stage 3: z
   logic            v3_ff;
   scr_pkg::ctx_type ctx3_ff;

   logic [W-1:0] ll_in;
   logic [W-1:0] cr_a_full, cr_b_full;
   logic [H-1:0] cr_sum;
   logic [W-1:0] y2_in;

   assign ll_in     = W'(counter[H-1:0]) * W'(key[H-1:0]);
   assign cr_a_full = W'(counter[H-1:0]) * W'(key[W-1:H]);
   assign cr_b_full = W'(counter[W-1:H]) * W'(key[H-1:0]);
   assign cr_sum    = cr_a_ff + cr_b_ff;
   assign y2_in     = ll_ff + {cr_sum, {H{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ll_ff    <= ll_in;
      cr_a_ff  <= cr_a_full[H-1:0];
      cr_b_ff  <= cr_b_full[H-1:0];
      key1_ff  <= key;
      last1_ff <= last_in;

      y2_ff    <= y2_in;
      key2_ff  <= key1_ff;
      last2_ff <= last1_ff;

      ctx3_ff.last <= last2_ff;
      ctx3_ff.y    <= y2_ff;
      ctx3_ff.z    <= y2_ff + key2_ff;
   end

   assign out_valid = v3_ff;
   assign out_ctx   = ctx3_ff;

endmodule

`default_nettype wire

// File: rtl/scr_round.sv
// One squaring round: x_out = swap_halves(x*x + addend), two register stages.
// Depends on scr_pkg.
`default_nettype none

module scr_round (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire scr_pkg::ctx_type              in_ctx,
   input  wire logic [scr_pkg::WordBits-1:0]  x,
   input  wire logic [scr_pkg::WordBits-1:0]  addend,
   output logic                               out_valid,
   output scr_pkg::ctx_type                   out_ctx,
   output logic [scr_pkg::WordBits-1:0]       x_out
);

   localparam int unsigned W = scr_pkg::WordBits;
   localparam int unsigned H = scr_pkg::HalfBits;

   logic             va_ff, vb_ff;
   logic [W-1:0]     ll_ff;
   logic [H-1:0]     cr_ff;
   logic [W-1:0]     add_ff;
   scr_pkg::ctx_type ctxa_ff, ctxb_ff;
   logic [W-1:0]     x_ff;

   logic [W-1:0] ll_in;
   logic [W-1:0] cr_full;
   logic [H-1:0] cr2;
   logic [W-1:0] sum;

   // square mod 2^64: lo*lo plus twice the low half of lo*hi, shifted up
   assign ll_in   = W'(x[H-1:0]) * W'(x[H-1:0]);
   assign cr_full = W'(x[H-1:0]) * W'(x[W-1:H]);
   assign cr2     = {cr_ff[H-2:0], 1'b0};
   assign sum     = ll_ff + {cr2, {H{1'b0}}} + add_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      cr_ff   <= cr_full[H-1:0];
      add_ff  <= addend;
      ctxa_ff <= in_ctx;

      x_ff    <= scr_pkg::swap_halves(sum);
      ctxb_ff <= ctxa_ff;
   end

   assign out_valid = vb_ff;
   assign out_ctx   = ctxb_ff;
   assign x_out     = x_ff;

endmodule

`default_nettype wire

// File: rtl/squares_counter_rng.sv
// Squares counter-based RNG: 32-bit word from a 64-bit counter and key.
// Pipeline: counter*key and z first, then each of four rounds in turn.
// Throughput one request per cycle; busy is always low, nothing stalls.
// The result shows on the rsp_ ports for one cycle with rsp_strobe high.
// Reset (synchronous) clears only the valid bits; no other state is kept.
// Depends on scr_pkg, scr_keymul, scr_round.
`default_nettype none

module squares_counter_rng (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [scr_pkg::WordBits-1:0]  req_counter,
   input  wire logic [scr_pkg::WordBits-1:0]  req_key,
   input  wire logic                          req_last_in,
   output logic                               rsp_strobe,
   output logic [scr_pkg::HalfBits-1:0]       rsp_random_word,
   output logic                               rsp_last_out
);

   localparam int unsigned W      = scr_pkg::WordBits;
   localparam int unsigned H      = scr_pkg::HalfBits;
   localparam int unsigned Rounds = 4;

   logic             v_s   [Rounds+1];
   scr_pkg::ctx_type ctx_s [Rounds+1];
   logic [W-1:0]     x_s   [Rounds+1];

   assign busy = 1'b0;

   scr_keymul u_keymul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .counter   (req_counter),
      .key       (req_key),
      .last_in   (req_last_in),
      .out_valid (v_s[0]),
      .out_ctx   (ctx_s[0])
   );

   assign x_s[0] = ctx_s[0].y;

   // addends run y, z, y, z
   for (genvar r = 0; r < Rounds; r++) begin : g_round
      scr_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_s[r]),
         .in_ctx    (ctx_s[r]),
         .x         (x_s[r]),
         .addend    ((r % 2 == 0) ? ctx_s[r].y : ctx_s[r].z),
         .out_valid (v_s[r+1]),
         .out_ctx   (ctx_s[r+1]),
         .x_out     (x_s[r+1])
      );
   end

   // last round is swapped too, so the upper half sits in the low bits
   assign rsp_strobe      = v_s[Rounds];
   assign rsp_random_word = x_s[Rounds][H-1:0];
   assign rsp_last_out    = ctx_s[Rounds].last;

endmodule

`default_nettype wire

// File: dv/squares_counter_rng_tb.sv
// Self-checking testbench for squares_counter_rng: drives counter/key requests and
// checks each 32-bit word and batch flag against an in-bench squares predictor.
// Depends on scr_pkg and the squares_counter_rng RTL.
`default_nettype none

module squares_counter_rng_tb;

   localparam int unsigned WordBits = scr_pkg::WordBits;
   localparam int unsigned HalfBits = scr_pkg::HalfBits;

   localparam int StallLimit = 4000;
   localparam int DrainCycles = 24;

   typedef struct packed {
      logic [HalfBits-1:0] word;
      logic                last;
   } draw_type;

   // Four-round middle-square Weyl draw, all arithmetic wraps at 64 bits
   function automatic logic [HalfBits-1:0] squares_word(input logic [WordBits-1:0] ctr,
                                                        input logic [WordBits-1:0] key);
      logic [WordBits-1:0] y;
      logic [WordBits-1:0] z;
      logic [WordBits-1:0] x;
      y = ctr * key;
      z = y + key;
      x = y * y + y;
      x = {x[HalfBits-1:0], x[WordBits-1:HalfBits]};
      x = x * x + z;
      x = {x[HalfBits-1:0], x[WordBits-1:HalfBits]};
      x = x * x + y;
      x = {x[HalfBits-1:0], x[WordBits-1:HalfBits]};
      x = x * x + z;
      return x[WordBits-1:HalfBits];
   endfunction

   class draw_ledger;
      draw_type expected_draws[$];
      int       failures;

      function void note_draw(input logic [WordBits-1:0] ctr, input logic [WordBits-1:0] key,
                              input logic last);
         draw_type d;
         d.word = squares_word(ctr, key);
         d.last = last;
         expected_draws.push_back(d);
      endfunction

      function void check_draw(input logic [HalfBits-1:0] word, input logic last);
         draw_type d;
         if (expected_draws.size() == 0) begin
            $error("random_word: no request pending, got %h", word);
            failures++;
            return;
         end
         d = expected_draws.pop_front();
         if (word !== d.word) begin
            $error("random_word: expected %h, got %h", d.word, word);
            failures++;
         end
         if (last !== d.last) begin
            $error("last_out: expected %b, got %b", d.last, last);
            failures++;
         end
      endfunction

      function int pending();
         return expected_draws.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [WordBits-1:0] req_counter;
   logic [WordBits-1:0] req_key;
   logic                req_last_in;
   logic                rsp_strobe;
   logic [HalfBits-1:0] rsp_random_word;
   logic                rsp_last_out;

   draw_ledger ledger = new;
   int         sender_idle_pct;
   int         quiet_cycles;

   squares_counter_rng uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_counter    (req_counter),
      .req_key        (req_key),
      .req_last_in    (req_last_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_random_word(rsp_random_word),
      .rsp_last_out   (rsp_last_out)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor and watchdog: everything sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) begin
            ledger.note_draw(req_counter, req_key, req_last_in);
         end
         if (rsp_strobe) begin
            ledger.check_draw(rsp_random_word, rsp_last_out);
         end
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("squares_counter_rng: mismatch");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Entered and left at a falling edge
   task automatic send_request(input logic [WordBits-1:0] ctr, input logic [WordBits-1:0] key,
                               input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_counter <= ctr;
      req_key     <= key;
      req_last_in <= last;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mix of full-range, extreme, small, one-hot and one-cold operands
   function automatic logic [WordBits-1:0] pick_operand();
      logic [WordBits-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = WordBits'($urandom_range(0, 15));
         3: v = WordBits'(1) << $urandom_range(0, WordBits-1);
         4: v = ~(WordBits'(1) << $urandom_range(0, WordBits-1));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(pick_operand(), pick_operand(), 1'($urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      logic [WordBits-1:0] ones;
      ones            = '1;
      reset           = 1'b1;
      start           = 1'b0;
      req_counter     = '0;
      req_key         = '0;
      req_last_in     = 1'b0;
      sender_idle_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero operands, extremes, bit patterns, flag both ways
      send_request('0, '0, 1'b0);
      send_request('0, ones, 1'b1);
      send_request(ones, '0, 1'b0);
      send_request(ones, ones, 1'b1);
      send_request(64'd1, 64'd1, 1'b0);
      send_request(ones, 64'd1, 1'b0);
      send_request(64'd1, ones, 1'b1);
      send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
      send_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
      send_request(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 1'b0);
      send_request(64'h0000_0000_0000_1234, 64'hB5AD_4ECE_DA1C_E2A9, 1'b1);
      wait_drained();

      sender_idle_pct = 9;
      run_random(270);
      wait_drained();

      sender_idle_pct = 62;
      run_random(260);
      wait_drained();

      sender_idle_pct = 0;
      run_random(270);
      wait_drained();

      repeat (DrainCycles) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("squares_counter_rng: match");
      end else begin
         $display("squares_counter_rng: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/scr_pkg.sv
rtl/scr_keymul.sv
rtl/scr_round.sv
rtl/squares_counter_rng.sv
dv/squares_counter_rng_tb.sv
